FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the odometry modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: design/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Types, constants and the arctangent table shared by the odometry modules.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int unsigned ATAN_ENTRIES = 24;
	localparam int unsigned ATAN_IDX_W   = 5;

	localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

	localparam logic [23:0] DIST_RESET  = 24'd5147;
	localparam logic [23:0] ANGLE_RESET = 24'd357913;

	localparam logic REG_DIST  = 1'b0;
	localparam logic REG_ANGLE = 1'b1;

	localparam int unsigned MUL_A_W = 34;
	localparam int unsigned MUL_B_W = 26;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL_D,
		S_MUL_H,
		S_MID,
		S_ROT,
		S_CORDIC,
		S_XL,
		S_XH,
		S_YL,
		S_YH,
		S_YF,
		S_YS,
		S_FIN
	} state_t;

	typedef struct packed {
		logic               done;
		logic signed [23:0] cos;
		logic signed [23:0] sin;
	} cordic_res_t;

	function automatic logic signed [31:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:    v = 32'sd536870912;
			5'd1:    v = 32'sd316933406;
			5'd2:    v = 32'sd167458907;
			5'd3:    v = 32'sd85004756;
			5'd4:    v = 32'sd42667331;
			5'd5:    v = 32'sd21354465;
			5'd6:    v = 32'sd10679838;
			5'd7:    v = 32'sd5340245;
			5'd8:    v = 32'sd2670163;
			5'd9:    v = 32'sd1335087;
			5'd10:   v = 32'sd667544;
			5'd11:   v = 32'sd333772;
			5'd12:   v = 32'sd166886;
			5'd13:   v = 32'sd83443;
			5'd14:   v = 32'sd41722;
			5'd15:   v = 32'sd20861;
			5'd16:   v = 32'sd10430;
			5'd17:   v = 32'sd5215;
			5'd18:   v = 32'sd2608;
			5'd19:   v = 32'sd1304;
			5'd20:   v = 32'sd652;
			5'd21:   v = 32'sd326;
			5'd22:   v = 32'sd163;
			5'd23:   v = 32'sd81;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/ddo_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, used for every product of an
// update under control of the sequencer.
// ----------------------------------------------------------------------------
module ddo_mul
	import ddo_pkg::*;
(
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

FILE: design/ddo_cordic.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC
// Folds a binary angle into the right half-plane and iterates one
// rotation step per cycle to give cosine and sine with 20 fraction bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ddo_cordic
	import ddo_pkg::*;
#(
	parameter int unsigned STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output cordic_res_t        res
);

	localparam int unsigned CW = $clog2(STEPS);
	localparam logic signed [32:0] HALF_PI = 33'sd1073741824;
	localparam logic signed [32:0] PI      = 33'sd2147483648;

	logic          busy_q;
	logic          fin_q;
	logic          neg_q;
	logic [CW-1:0] step_q;

	logic signed [31:0] x_q, y_q, z_q;

	logic signed [32:0] z_ext, z_fold;
	logic               neg_fold;
	logic signed [31:0] xs, ys, at, nx, ny, nz, xf, yf;
	logic               last;

	always_comb begin
		z_ext    = 33'(angle);
		z_fold   = z_ext;
		neg_fold = 1'b0;
		if (z_ext > HALF_PI) begin
			z_fold   = z_ext - PI;
			neg_fold = 1'b1;
		end else if (z_ext < -HALF_PI) begin
			z_fold   = z_ext + PI;
			neg_fold = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = atan_lookup(ATAN_IDX_W'(step_q));
		if (!z_q[31]) begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - at;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + at;
		end
	end

	assign last = (step_q == CW'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			neg_q  <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= neg_fold;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= z_fold[31:0];
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
	end

	assign xf = neg_q ? -x_q : x_q;
	assign yf = neg_q ? -y_q : y_q;

	assign res.done = fin_q;
	assign res.cos  = xf[31:8];
	assign res.sin  = yf[31:8];

	`ASSERT_IMPLIES(a_fin_not_busy, clk, arst_n, fin_q, !busy_q)
	`ASSERT_IMPLIES(a_start_when_free, clk, arst_n, start, !busy_q && !fin_q)
	`ASSERT_NEXT(a_last_step_done, clk, arst_n, busy_q && last && !start, fin_q && !busy_q)

endmodule

FILE: design/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Pose tracker for a two-wheeled base: set pose or integrate encoder counts
// with midpoint-heading dead reckoning.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the input channel (in_valid, in_stall) with an op bit:
// a set item loads pos and heading and latches both encoder counts; an update
// item takes raw counts, forms wrapped deltas and moves the pose. Every item
// gives one result on the output channel (out_valid, out_stall): the moved
// flag and the pose after the item. The user must write registers on the cfg
// port only while the block is idle; the block itself does not enforce this.
// Sequence. A set item or an update with no tick change goes from decode
// straight to the final state. A moving update forms the distance, heading
// and midpoint, runs the CORDIC, which rotates one step per cycle, and uses
// the single shared multiplier six times in sequence.
// A finished result sits in the output register; the next input is taken
// while it waits; only the final state, which loads it, stalls while it is held.
// Reset clears the pose, the latched counts and the output valid, and loads
// the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module differential_drive_odometry
	import ddo_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic signed [31:0] new_x,
	input  logic signed [31:0] new_y,
	input  logic signed [15:0] new_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               moved,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [15:0] heading
);

	localparam logic signed [MUL_P_W-1:0] D_LIMIT = MUL_P_W'(64'sd2199023255552);

	state_t state_q, state_d;

	logic [23:0] dist_q, angle_q;
	logic [31:0] pose_x_q, pose_y_q, head_q, last_l_q, last_r_q;
	logic        out_valid_q;

	logic               op_q;
	logic [31:0]        lc_q, rc_q, nx_q, ny_q;
	logic [15:0]        nh_q;
	logic signed [32:0] sum_q, diff_q;
	logic signed [42:0] d_q;
	logic [31:0]        dh_q, mid_q;
	logic signed [23:0] cos_q, sin_q;
	logic signed [63:0] acc_q;
	logic               moved_q;
	logic               moved_o;
	logic [31:0]        pos_x_o, pos_y_o;
	logic [15:0]        heading_o;

	logic [31:0]                dl, dr;
	logic                       zero_delta;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [MUL_P_W-1:0]  prod;
	logic signed [MUL_P_W-1:0]  half_d;
	logic signed [42:0]         d_next;
	logic signed [63:0]         prod_ext;
	logic                       cordic_start;
	logic                       out_load;
	cordic_res_t                cordic_res;

	function automatic logic [31:0] sat_add(input logic [31:0] acc, input logic signed [35:0] dv);
		logic signed [36:0] s;
		logic [31:0]        r;
		s = 37'(signed'(acc)) + 37'(dv);
		if (s > 37'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (s < -37'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	ddo_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ddo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (signed'(mid_q)),
		.res    (cordic_res)
	);

	assign dl         = lc_q - last_l_q;
	assign dr         = rc_q - last_r_q;
	assign zero_delta = (dl == 32'd0) && (dr == 32'd0);
	assign prod_ext   = 64'(prod);

	always_comb begin
		half_d = prod >>> 1;
		if (half_d > D_LIMIT) begin
			d_next = D_LIMIT[42:0];
		end else if (half_d < -D_LIMIT) begin
			d_next = -D_LIMIT[42:0];
		end else begin
			d_next = half_d[42:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: state_d = (op_q || zero_delta) ? S_FIN : S_MUL_D;
			S_MUL_D:  state_d = S_MUL_H;
			S_MUL_H:  state_d = S_MID;
			S_MID:    state_d = S_ROT;
			S_ROT:    state_d = S_CORDIC;
			S_CORDIC: if (cordic_res.done) state_d = S_XL;
			S_XL:     state_d = S_XH;
			S_XH:     state_d = S_YL;
			S_YL:     state_d = S_YH;
			S_YH:     state_d = S_YF;
			S_YF:     state_d = S_YS;
			S_YS:     state_d = S_FIN;
			S_FIN:    if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != S_IDLE);
		cordic_start = (state_q == S_ROT);
		out_load     = (state_q == S_FIN) && (!out_valid_q || !out_stall);
		mul_a        = '0;
		mul_b        = '0;
		unique case (state_q)
			S_MUL_D: begin
				mul_a = MUL_A_W'(sum_q);
				mul_b = {2'b00, dist_q};
			end
			S_MUL_H: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = {2'b00, angle_q};
			end
			S_XL: begin
				mul_a = {12'd0, d_q[21:0]};
				mul_b = MUL_B_W'(cos_q);
			end
			S_XH: begin
				mul_a = MUL_A_W'(signed'(d_q[42:22]));
				mul_b = MUL_B_W'(cos_q);
			end
			S_YL: begin
				mul_a = {12'd0, d_q[21:0]};
				mul_b = MUL_B_W'(sin_q);
			end
			S_YH: begin
				mul_a = MUL_A_W'(signed'(d_q[42:22]));
				mul_b = MUL_B_W'(sin_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dist_q      <= DIST_RESET;
			angle_q     <= ANGLE_RESET;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			head_q      <= '0;
			last_l_q    <= '0;
			last_r_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIST:  dist_q  <= cfg_data;
					REG_ANGLE: angle_q <= cfg_data;
				endcase
			end
			if (state_q == S_DECODE && op_q) begin
				pose_x_q <= nx_q;
				pose_y_q <= ny_q;
				head_q   <= {nh_q, 16'd0};
				last_l_q <= lc_q;
				last_r_q <= rc_q;
			end
			if (state_q == S_YH) begin
				pose_x_q <= sat_add(pose_x_q, acc_q[63:28]);
			end
			if (state_q == S_YS) begin
				pose_y_q <= sat_add(pose_y_q, acc_q[63:28]);
				head_q   <= head_q + dh_q;
				last_l_q <= lc_q;
				last_r_q <= rc_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= op;
			lc_q <= left_count;
			rc_q <= right_count;
			nx_q <= new_x;
			ny_q <= new_y;
			nh_q <= new_heading;
		end
		unique case (state_q)
			S_DECODE: begin
				sum_q   <= 33'(signed'(dl)) + 33'(signed'(dr));
				diff_q  <= 33'(signed'(dr)) - 33'(signed'(dl));
				moved_q <= 1'b0;
			end
			S_MUL_H:  d_q <= d_next;
			S_MID: begin
				dh_q  <= prod[31:0];
				mid_q <= head_q + prod[32:1];
			end
			S_CORDIC: begin
				cos_q <= cordic_res.cos;
				sin_q <= cordic_res.sin;
			end
			S_XH:     acc_q <= prod_ext;
			S_YL:     acc_q <= acc_q + (prod_ext <<< 22);
			S_YH:     acc_q <= prod_ext;
			S_YF:     acc_q <= acc_q + (prod_ext <<< 22);
			S_YS:     moved_q <= 1'b1;
			default: begin
			end
		endcase
		if (out_load) begin
			moved_o   <= moved_q;
			pos_x_o   <= pose_x_q;
			pos_y_o   <= pose_y_q;
			heading_o <= head_q[31:16];
		end
	end

	assign out_valid = out_valid_q;
	assign moved     = moved_o;
	assign pos_x     = signed'(pos_x_o);
	assign pos_y     = signed'(pos_y_o);
	assign heading   = signed'(heading_o);

	`ASSERT_IMPLIES(a_done_while_waiting, clk, arst_n, cordic_res.done, state_q == S_CORDIC)
	`ASSERT_NEXT(a_transfer_decodes, clk, arst_n, in_valid && !in_stall, state_q == S_DECODE)
	`ASSERT_IMPLIES(a_result_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_FIN)

endmodule
